// File: rtl/esd_pkg.sv
// Package for the escape sequence decoder: result types, decode modes,
// character constants and the hex digit helper. No dependencies.
package esd_pkg;

  // Characters the decoder recognises.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Digits a numeric escape may hold before it is emitted.
  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

  // Decoder mode.
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_OCT   = 2'd3
  } mode_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       eos;
  } res_t;

  // Results caused by one input beat, first result in r0.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } pair_t;

  // Hex digit value; bit 4 is set when the character is a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
      return {1'b1, d[3:0]};
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// File: rtl/esd_if.sv
// Channel interfaces of the escape sequence decoder: the source byte
// channel and the decoded result channel. No dependencies.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_end;

  modport source (output valid, out_byte, out_valid, out_end, input ready);
  modport sink   (input valid, out_byte, out_valid, out_end, output ready);
endinterface

// File: rtl/esd_step.sv
// Decode step: escape state registers and the logic that turns one source
// byte into up to two results. Depends on esd_pkg.
module esd_step import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] b,
  input  logic       last,
  output pair_t      pair
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] val_r, val_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic       flush_en, ch_en, plain, any;
  logic [7:0] flush_byte, ch_byte, acc;
  logic [4:0] hv;
  logic [7:0] oct_d;
  logic [1:0] cnt_inc;

  // Work out the next state and the results of this beat.
  always_comb begin
    mode_nxt   = mode_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    flush_en   = 1'b0;
    flush_byte = 8'h00;
    ch_en      = 1'b0;
    ch_byte    = b;
    plain      = 1'b0;
    any        = 1'b0;
    hv         = hex_val(b);
    oct_d      = b - CH_ZERO;
    cnt_inc    = cnt_r + 2'd1;
    acc        = 8'h00;
    pair       = '0;

    case (mode_r)
      MODE_PLAIN: begin
        plain = 1'b1;
      end
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        val_nxt  = 8'h00;
        cnt_nxt  = 2'd0;
        if (b == CH_T) begin
          ch_en   = 1'b1;
          ch_byte = CH_TAB;
        end else if (b == CH_N) begin
          ch_en   = 1'b1;
          ch_byte = CH_LF;
        end else if (b == CH_R) begin
          ch_en   = 1'b1;
          ch_byte = CH_CR;
        end else if (b == CH_X) begin
          mode_nxt = MODE_HEX;
        end else if (b inside {[CH_ZERO:CH_SEVEN]}) begin
          mode_nxt = MODE_OCT;
          val_nxt  = oct_d;
          cnt_nxt  = 2'd1;
        end else if (b != CH_LF) begin
          ch_en = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hv[4]) begin
          acc     = {val_r[3:0], hv[3:0]};
          val_nxt = acc;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= HEX_DIGITS) begin
            flush_en   = 1'b1;
            flush_byte = acc;
            mode_nxt   = MODE_PLAIN;
            val_nxt    = 8'h00;
            cnt_nxt    = 2'd0;
          end
        end else begin
          flush_en   = 1'b1;
          flush_byte = val_r;
          mode_nxt   = MODE_PLAIN;
          val_nxt    = 8'h00;
          cnt_nxt    = 2'd0;
          plain      = 1'b1;
        end
      end
      default: begin
        if (b inside {[CH_ZERO:CH_SEVEN]}) begin
          acc     = {val_r[4:0], oct_d[2:0]};
          val_nxt = acc;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= OCT_DIGITS) begin
            flush_en   = 1'b1;
            flush_byte = acc;
            mode_nxt   = MODE_PLAIN;
            val_nxt    = 8'h00;
            cnt_nxt    = 2'd0;
          end
        end else begin
          flush_en   = 1'b1;
          flush_byte = val_r;
          mode_nxt   = MODE_PLAIN;
          val_nxt    = 8'h00;
          cnt_nxt    = 2'd0;
          plain      = 1'b1;
        end
      end
    endcase

    // A byte in plain mode either opens an escape or passes through.
    if (plain) begin
      if (b == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        ch_en   = 1'b1;
        ch_byte = b;
      end
    end

    // End of string: a pending numeric escape is emitted, state returns to reset.
    if (last) begin
      if (mode_nxt == MODE_HEX || mode_nxt == MODE_OCT) begin
        flush_en   = 1'b1;
        flush_byte = val_nxt;
      end
      mode_nxt = MODE_PLAIN;
      val_nxt  = 8'h00;
      cnt_nxt  = 2'd0;
    end

    // Pack the results in order.
    any = flush_en | ch_en;
    if (flush_en && ch_en) begin
      pair.count = 2'd2;
      pair.r0    = '{data: flush_byte, vld: 1'b1, eos: 1'b0};
      pair.r1    = '{data: ch_byte, vld: 1'b1, eos: last};
    end else if (any) begin
      pair.count = 2'd1;
      pair.r0    = '{data: (flush_en ? flush_byte : ch_byte), vld: 1'b1, eos: last};
    end else if (last) begin
      pair.count = 2'd1;
      pair.r0    = '{data: 8'h00, vld: 1'b0, eos: 1'b1};
    end
  end

  // State registers move on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      val_r  <= 8'h00;
      cnt_r  <= 2'd0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      val_r  <= val_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: rtl/esd_outbuf.sv
// Result register of the decoder: holds the up to two results of one beat
// and hands one out per cycle while res_ready is high. Depends on esd_pkg.
module esd_outbuf import esd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  pair_t pair,
  output logic  can_load,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  res_t       slot0_r, slot1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign res_valid = (cnt_r != 2'd0);
  assign res       = slot0_r;
  assign pop       = res_valid & res_ready;
  // New results may enter once the last held result leaves.
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  // Count of results still held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load && pair.count != 2'd0) begin
      cnt_r <= pair.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Result slots; the second moves forward when the first is taken.
  always_ff @(posedge clk) begin
    if (load && pair.count != 2'd0) begin
      slot0_r <= pair.r0;
      slot1_r <= pair.r1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

// File: rtl/escape_sequence_decoder_top.sv
// Escape sequence decoder, top level: joins the decode step and the result
// register to the channels. Depends on esd_pkg, esd_if, esd_step, esd_outbuf.
//
// The decoder takes one source byte per cycle while results are taken
// as they appear, and turns C-style escapes into bytes. A byte's first
// result appears the cycle after the byte is accepted. Most bytes give
// one result, taken at one per cycle while output ready is high. A
// non-digit byte ending a numeric escape can give two (the value, then
// the byte); it holds the input while the second result is handed out.
// Input ready is high while the result register is empty, or while it
// holds a single result that leaves in the same cycle, so input ready
// depends on output ready within the cycle.
// The last result of each string carries out_end; a string whose final
// byte gives nothing yields one result with out_valid low.
module escape_sequence_decoder_top import esd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);

  pair_t pair;
  res_t  res;
  logic  can_load;
  logic  accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid & can_load;

  // Decode logic and escape state.
  esd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .b       (in_ch.in_byte),
    .last    (in_ch.in_last),
    .pair    (pair)
  );

  // Result register.
  esd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .pair      (pair),
    .can_load  (can_load),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.out_byte  = res.data;
  assign out_ch.out_valid = res.vld;
  assign out_ch.out_end   = res.eos;

endmodule

// File: bench/escape_sequence_decoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for escape_sequence_decoder_top: a predictor of the C-style
// escape decoding is checked against every result beat. Depends on esd_pkg and esd_if.
module escape_sequence_decoder_top_test;
  import esd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BEATS = 1650;
  localparam int CALM_TAIL = 150;
  localparam int HOLD_AFTER = 600;
  localparam int HOLD_CYCLES = 80;

  // One source character with its end-of-string flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } src_t;

  logic clk = 1'b0;
  logic rst_n;

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  escape_sequence_decoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  src_t pending[$];
  res_t expected_q[$];
  res_t beat_results[$];

  // Predictor state.
  mode_t      dec_mode;
  logic [7:0] dec_val;
  logic [1:0] dec_cnt;

  bit in_fire;
  int beats_in;
  int err_count;
  int cycle_count;
  int send_gap;
  int stall_left;
  int hold_left;
  bit hold_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor.
  function void clear_escape();
    dec_mode = MODE_PLAIN;
    dec_val  = 8'h00;
    dec_cnt  = 2'd0;
  endfunction

  function void emit_byte(input logic [7:0] d, input logic v);
    res_t r;
    r.data = d;
    r.vld  = v;
    r.eos  = 1'b0;
    beat_results.push_back(r);
  endfunction

  function void take_plain(input logic [7:0] b);
    if (b == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      emit_byte(b, 1'b1);
    end
  endfunction

  // Works out the results of one accepted source beat and queues them.
  function void decode_beat(input logic [7:0] b, input logic last);
    logic [7:0] nib;
    logic       is_hex;
    beat_results.delete();
    is_hex = 1'b1;
    nib = 8'h00;
    if (b >= CH_ZERO && b <= 8'h39) begin
      nib = b - CH_ZERO;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      nib = b - 8'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      nib = b - 8'h37;
    end else begin
      is_hex = 1'b0;
    end

    case (dec_mode)
      MODE_PLAIN: begin
        take_plain(b);
      end
      MODE_ESC: begin
        clear_escape();
        if (b == CH_T) begin
          emit_byte(CH_TAB, 1'b1);
        end else if (b == CH_N) begin
          emit_byte(CH_LF, 1'b1);
        end else if (b == CH_R) begin
          emit_byte(CH_CR, 1'b1);
        end else if (b == CH_X) begin
          dec_mode = MODE_HEX;
        end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
          dec_mode = MODE_OCT;
          dec_val  = b - CH_ZERO;
          dec_cnt  = 2'd1;
        end else if (b != CH_LF) begin
          // A backslash before a line feed is a continuation and gives nothing.
          emit_byte(b, 1'b1);
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          dec_val = {dec_val[3:0], nib[3:0]};
          dec_cnt = dec_cnt + 2'd1;
          if (dec_cnt >= HEX_DIGITS) begin
            emit_byte(dec_val, 1'b1);
            clear_escape();
          end
        end else begin
          // The escape value goes out first, then the byte is decoded as plain text.
          emit_byte(dec_val, 1'b1);
          clear_escape();
          take_plain(b);
        end
      end
      default: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          dec_val = {dec_val[4:0], b[2:0]};
          dec_cnt = dec_cnt + 2'd1;
          if (dec_cnt >= OCT_DIGITS) begin
            emit_byte(dec_val, 1'b1);
            clear_escape();
          end
        end else begin
          emit_byte(dec_val, 1'b1);
          clear_escape();
          take_plain(b);
        end
      end
    endcase

    // End of string: flush an open numeric escape and mark the final result.
    if (last) begin
      if (dec_mode == MODE_HEX || dec_mode == MODE_OCT) begin
        emit_byte(dec_val, 1'b1);
      end
      clear_escape();
      if (beat_results.size() == 0) begin
        emit_byte(8'h00, 1'b0);
      end
      beat_results[beat_results.size() - 1].eos = 1'b1;
    end

    foreach (beat_results[i]) begin
      expected_q.push_back(beat_results[i]);
    end
  endfunction

  // Stimulus helpers.
  task automatic add_byte(input logic [7:0] b, input bit last);
    src_t s;
    s.ch  = b;
    s.fin = last;
    pending.push_back(s);
  endtask

  task automatic add_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i], ends && (i == s.len() - 1));
    end
  endtask

  // One random string: a mix of plain bytes and escapes of each kind with random content.
  task automatic gen_phrase();
    logic [7:0] text[$];
    int         ntok;
    int         ndig;
    logic [7:0] b;
    logic [7:0] v;
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          b = 8'($urandom_range(1, 255));
          if (b == CH_BSLASH) begin
            b = CH_X;
          end
          text.push_back(b);
        end
        3: begin
          text.push_back(CH_BSLASH);
          case ($urandom_range(0, 3))
            0:       text.push_back(CH_T);
            1:       text.push_back(CH_N);
            2:       text.push_back(CH_R);
            default: text.push_back(8'($urandom_range(8'h20, 8'h7E)));
          endcase
        end
        4: begin
          text.push_back(CH_BSLASH);
          text.push_back(CH_X);
          ndig = $urandom_range(0, 2);
          repeat (ndig) begin
            v = 8'($urandom_range(0, 15));
            if (v < 10) begin
              b = CH_ZERO + v;
            end else if ($urandom_range(0, 1)) begin
              b = 8'h57 + v;
            end else begin
              b = 8'h37 + v;
            end
            text.push_back(b);
          end
        end
        5: begin
          text.push_back(CH_BSLASH);
          ndig = $urandom_range(1, 3);
          repeat (ndig) begin
            text.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
          end
        end
        6: begin
          text.push_back(CH_BSLASH);
          text.push_back(CH_LF);
        end
        7: begin
          text.push_back(CH_BSLASH);
          text.push_back(8'($urandom_range(1, 255)));
        end
        8: begin
          text.push_back(8'($urandom_range(1, 255)));
        end
        default: begin
          text.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
      endcase
    end
    // Now and then the string ends on a lone backslash.
    if ($urandom_range(0, 7) == 0) begin
      text.push_back(CH_BSLASH);
    end
    foreach (text[i]) begin
      add_byte(text[i], i == text.size() - 1);
    end
  endtask

  // Source side: offers queued beats, with random idle bursts.
  always @(negedge clk) begin : drive_source
    src_t item;
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending.size() > CALM_TAIL && hold_left == 0 &&
                   $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_ch.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        item = pending.pop_front();
        in_ch.in_byte <= item.ch;
        in_ch.in_last <= item.fin;
        in_ch.valid   <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && beats_in >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (pending.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted source beat, checks each accepted result beat.
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire) begin
      beats_in = beats_in + 1;
      decode_beat(in_ch.in_byte, in_ch.in_last);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data = out_ch.out_byte;
      got.vld  = out_ch.out_valid;
      got.eos  = out_ch.out_end;
      if (expected_q.size() == 0) begin
        err_count = err_count + 1;
        $display("%0t: unexpected result: expected none, got byte %h valid %b end %b",
                 $time, got.data, got.vld, got.eos);
      end else begin
        want = expected_q.pop_front();
        if (got.data !== want.data || got.vld !== want.vld || got.eos !== want.eos) begin
          err_count = err_count + 1;
          $display("%0t: result mismatch: expected byte %h valid %b end %b,",
                   $time, want.data, want.vld, want.eos);
          $display("%0t:   got byte %h valid %b end %b",
                   $time, got.data, got.vld, got.eos);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("escape_sequence_decoder_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
    clear_escape();

    // Directed part: byte FF, named, hex, octal and continuation escapes, corner cases.
    add_byte(8'hFF, 1'b0);
    add_text("\\t\\n\\r", 1'b0);
    add_text("\\x4f", 1'b0);
    add_text("\\xg", 1'b0);
    add_text("\\777", 1'b0);
    add_text("\\19", 1'b0);
    add_text("\\\n", 1'b1);
    add_byte(CH_BSLASH, 1'b1);
    add_text("\\xA", 1'b1);

    while (pending.size() < RANDOM_BEATS + 27) begin
      gen_phrase();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending.size() != 0 || in_ch.valid || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (err_count == 0) begin
      $display("escape_sequence_decoder_top regression: pass");
    end else begin
      $display("escape_sequence_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/esd_pkg.sv
rtl/esd_if.sv
rtl/esd_step.sv
rtl/esd_outbuf.sv
rtl/escape_sequence_decoder_top.sv
bench/escape_sequence_decoder_top_test.sv
